@@ hw/rtl/ssvt_pkg.sv @@
// ssvt_pkg: shared types and constants for the sorted sparse vector table
// depends on nothing; imported by ssvt_cell, sorted_sparse_vector_table and the bench

package ssvt_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 16;
	localparam int VAL_W    = 8;
	localparam int FUNC_W   = 2;
	localparam int ENTRY_W  = 7;

	localparam logic [FUNC_W-1:0] OP_GET    = 2'd0;
	localparam logic [FUNC_W-1:0] OP_SET    = 2'd1;
	localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [0:0] STATUS_OK   = 1'b0;
	localparam logic [0:0] STATUS_FULL = 1'b1;

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic             cmp_en; // latch compare flags against pos
		logic [POS_W-1:0] pos;    // compare key, or index for an insert
		logic [VAL_W-1:0] val;    // byte for an insert or an overwrite
		logic             ins;    // open a gap at the insert point
		logic             rem;    // close the gap above the hit
		logic             wr;     // overwrite the hit entry
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_APPLY = 2'b10
	} state_t;

endpackage

@@ hw/rtl/ssvt_cell.sv @@
// ssvt_cell: one slot of the sorted table with its compare flags and shift mux
// depends on ssvt_pkg

module ssvt_cell (
	input  logic                      clk,
	input  ssvt_pkg::cell_cmd_t       cmd,
	input  logic                      occ,
	input  logic                      lt_prev,
	input  logic [ssvt_pkg::POS_W-1:0] prev_idx,
	input  logic [ssvt_pkg::VAL_W-1:0] prev_val,
	input  logic [ssvt_pkg::POS_W-1:0] next_idx,
	input  logic [ssvt_pkg::VAL_W-1:0] next_val,
	output logic [ssvt_pkg::POS_W-1:0] idx,
	output logic [ssvt_pkg::VAL_W-1:0] val,
	output logic                      lt,
	output logic                      eq,
	output logic [ssvt_pkg::VAL_W-1:0] hit_val
);
	import ssvt_pkg::*;

	logic [POS_W-1:0] idx_q;
	logic [VAL_W-1:0] val_q;
	logic             lt_q;
	logic             eq_q;

	// flags are only read in the cycle after a compare
	always_ff @(posedge clk) begin
		if (cmd.cmp_en) begin
			lt_q <= occ && (idx_q < cmd.pos);
			eq_q <= occ && (idx_q == cmd.pos);
		end
	end

	// on an insert or a remove, cells below the key hold and the rest shift; a write changes only the hit cell
	always_ff @(posedge clk) begin
		if (cmd.ins && !lt_q) begin
			if (lt_prev) begin
				idx_q <= cmd.pos;
				val_q <= cmd.val;
			end else begin
				idx_q <= prev_idx;
				val_q <= prev_val;
			end
		end else if (cmd.rem && !lt_q) begin
			idx_q <= next_idx;
			val_q <= next_val;
		end else if (cmd.wr && eq_q) begin
			val_q <= cmd.val;
		end
	end

	assign idx     = idx_q;
	assign val     = val_q;
	assign lt      = lt_q;
	assign eq      = eq_q;
	assign hit_val = eq_q ? val_q : '0;

endmodule

@@ hw/rtl/sorted_sparse_vector_table.sv @@
// sorted_sparse_vector_table: top level, controller and the row of cells
// depends on ssvt_pkg and ssvt_cell

// sparse byte vector held as up to CAPACITY (index, value) pairs in a row
// of cells, kept in ascending index order. each request word is a get, a
// set or a remove at one 16-bit position (func 3 behaves as a get) and
// gives exactly one response word: the byte held there before the
// operation (0 if absent), whether it was present, a status bit (1 when a
// new entry was refused because the table is full) and the entry count
// afterwards, modulo 128. a set of zero at an absent position inserts
// nothing. in the cycle an item is accepted every cell compares its
// stored index with the position in parallel, and in the next cycle the
// cells from the key upward shift up or down by one slot, or one cell is
// overwritten, while the response is registered. req_ready returns once
// the controller is back from the update state to idle and the response
// slot is empty or its word is being taken, so no new item is accepted
// before the last has finished its update. the table starts empty after
// reset and needs no clearing pass; contents past the entry count are unused.

module sorted_sparse_vector_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [ssvt_pkg::FUNC_W-1:0]  func,
	input  logic [ssvt_pkg::POS_W-1:0]   position,
	input  logic [ssvt_pkg::VAL_W-1:0]   new_value,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [ssvt_pkg::VAL_W-1:0]   read_value,
	output logic                        found,
	output logic                        status,
	output logic [ssvt_pkg::ENTRY_W-1:0] entry_count
);
	import ssvt_pkg::*;

	state_t state_q;

	// request word held for the update cycle
	logic [FUNC_W-1:0] func_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [VAL_W-1:0]  val_s1;

	logic [CNT_W-1:0]  count_q;

	// response register
	logic               rsp_valid_q;
	logic [VAL_W-1:0]   read_value_q;
	logic               found_q;
	logic               status_q;
	logic [ENTRY_W-1:0] entry_count_q;

	// row wiring
	logic [POS_W-1:0] idx_w [CAPACITY];
	logic [VAL_W-1:0] val_w [CAPACITY];
	logic [VAL_W-1:0] hit_w [CAPACITY];
	logic [CAPACITY-1:0] lt_w;
	logic [CAPACITY-1:0] eq_w;
	logic [CAPACITY-1:0] occ_w;

	cell_cmd_t cmd;

	logic             accept;
	logic             applying;
	logic             hit;
	logic [VAL_W-1:0] hit_value;
	logic             full;
	logic             do_ins;
	logic             do_rem;
	logic             do_wr;
	logic             refused;
	logic [CNT_W-1:0] count_next;

	// one request in flight; the response slot must be free or draining
	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign applying  = (state_q == ST_APPLY);

	// hit detection across the row, flags were latched at acceptance
	assign hit = |eq_w;
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_value = hit_value | hit_w[i];
		end
	end

	assign full    = (count_q == CNT_W'(CAPACITY));
	assign do_wr   = applying && (func_s1 == OP_SET) && hit;
	assign refused = applying && (func_s1 == OP_SET) && !hit && (val_s1 != '0) && full;
	assign do_ins  = applying && (func_s1 == OP_SET) && !hit && (val_s1 != '0) && !full;
	assign do_rem  = applying && (func_s1 == OP_REMOVE) && hit;

	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// compare key comes straight from the port at acceptance
	always_comb begin
		cmd.cmp_en = accept;
		cmd.pos    = applying ? pos_s1 : position;
		cmd.val    = val_s1;
		cmd.ins    = do_ins;
		cmd.rem    = do_rem;
		cmd.wr     = do_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					state_q <= ST_IDLE;
					count_q <= count_next;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			pos_s1  <= position;
			val_s1  <= new_value;
		end
	end

	// response word, loaded in the update cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (applying) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (applying) begin
			read_value_q  <= hit ? hit_value : '0;
			found_q       <= hit;
			status_q      <= refused ? STATUS_FULL : STATUS_OK;
			entry_count_q <= ENTRY_W'(count_next);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign read_value  = read_value_q;
	assign found       = found_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	// the row: cell i takes from i-1 on an insert and from i+1 on a remove
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic             lt_prev;
		logic [POS_W-1:0] prev_idx;
		logic [VAL_W-1:0] prev_val;
		logic [POS_W-1:0] next_idx;
		logic [VAL_W-1:0] next_val;

		assign occ_w[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign lt_prev  = 1'b1;
			assign prev_idx = '0;
			assign prev_val = '0;
		end else begin : g_mid
			assign lt_prev  = lt_w[i-1];
			assign prev_idx = idx_w[i-1];
			assign prev_val = val_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_idx = idx_w[i];
			assign next_val = val_w[i];
		end else begin : g_inner
			assign next_idx = idx_w[i+1];
			assign next_val = val_w[i+1];
		end

		ssvt_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occ      (occ_w[i]),
			.lt_prev  (lt_prev),
			.prev_idx (prev_idx),
			.prev_val (prev_val),
			.next_idx (next_idx),
			.next_val (next_val),
			.idx      (idx_w[i]),
			.val      (val_w[i]),
			.lt       (lt_w[i]),
			.eq       (eq_w[i]),
			.hit_val  (hit_w[i])
		);
	end

endmodule

@@ verif/sorted_sparse_vector_table_tb.sv @@
// sorted_sparse_vector_table_tb: self-checking bench for the sorted sparse vector table
// depends on ssvt_pkg and sorted_sparse_vector_table; drives request words with bursts
// and gaps, stalls the response side, and checks every response against its own predictor
`timescale 1ns / 1ps

module sorted_sparse_vector_table_tb;

	import ssvt_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 200;
	localparam int NUM_PHASES   = 8;
	localparam int POOL_MAX     = 72;

	// func 3 has no name in the package; the block treats it as a get
	localparam logic [FUNC_W-1:0] OP_SPARE = 2'd3;

	typedef enum int {
		PH_FILL,
		PH_CHURN,
		PH_DRAIN,
		PH_WIDE
	} phase_kind_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  new_value;
	} vec_req_t;

	typedef struct packed {
		logic [VAL_W-1:0]   read_value;
		logic               found;
		logic               status;
		logic [ENTRY_W-1:0] entry_count;
	} vec_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               req_valid = 1'b0;
	logic               req_ready;
	logic [FUNC_W-1:0]  func = '0;
	logic [POS_W-1:0]   position = '0;
	logic [VAL_W-1:0]   new_value = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic [VAL_W-1:0]   read_value;
	logic               found;
	logic               status;
	logic [ENTRY_W-1:0] entry_count;

	sorted_sparse_vector_table u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.func        (func),
		.position    (position),
		.new_value   (new_value),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.read_value  (read_value),
		.found       (found),
		.status      (status),
		.entry_count (entry_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// words waiting to be offered, and responses owed by the block in order
	vec_req_t pending_reqs[$];
	vec_rsp_t owed_rsps[$];

	// shadow copy of the sorted table
	logic [POS_W-1:0] shadow_pos[CAPACITY];
	logic [VAL_W-1:0] shadow_val[CAPACITY];
	int               shadow_used = 0;

	int mismatches = 0;
	int words_sent = 0;
	int words_seen = 0;
	int hits_seen = 0;
	int refusals_seen = 0;
	int peak_used = 0;
	int cycles = 0;

	// bumped by the stimulus to ask the receiver for a long hold-off
	int hold_req = 0;

	// apply one word to the shadow table and return the response it owes
	function automatic vec_rsp_t apply_vector_op(input vec_req_t rq);
		int       slot;
		bit       hit;
		vec_rsp_t r;
		slot = 0;
		while (slot < shadow_used && shadow_pos[slot] < rq.position)
			slot++;
		hit = (slot < shadow_used) && (shadow_pos[slot] == rq.position);
		r.read_value = hit ? shadow_val[slot] : '0;
		r.found      = hit;
		r.status     = STATUS_OK;
		case (rq.func)
			OP_SET: begin
				if (hit) begin
					shadow_val[slot] = rq.new_value;
				end else if (rq.new_value != '0) begin
					if (shadow_used >= CAPACITY) begin
						r.status = STATUS_FULL;
					end else begin
						for (int k = shadow_used; k > slot; k--) begin
							shadow_pos[k] = shadow_pos[k-1];
							shadow_val[k] = shadow_val[k-1];
						end
						shadow_pos[slot] = rq.position;
						shadow_val[slot] = rq.new_value;
						shadow_used++;
					end
				end
			end
			OP_REMOVE: begin
				if (hit) begin
					for (int k = slot; k + 1 < shadow_used; k++) begin
						shadow_pos[k] = shadow_pos[k+1];
						shadow_val[k] = shadow_val[k+1];
					end
					shadow_used--;
				end
			end
			default: ; // get, and the spare code acting as a get
		endcase
		r.entry_count = ENTRY_W'(shadow_used);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// driver: offers queued words in bursts, with random gaps between
	// ---------------------------------------------------------------
	int       burst_left = 0;
	int       gap_left = 0;
	int       gap_pick;
	vec_req_t next_req;
	vec_rsp_t owed;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid  <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			// a word taken at this edge gets its response predicted now
			if (req_valid && req_ready) begin
				owed = apply_vector_op({func, position, new_value});
				owed_rsps.push_back(owed);
				words_sent++;
				if (owed.found)
					hits_seen++;
				if (owed.status == STATUS_FULL)
					refusals_seen++;
				if (shadow_used > peak_used)
					peak_used = shadow_used;
			end
			// valid only moves when nothing is on offer or the offer was taken
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					gap_left  <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					next_req = pending_reqs.pop_front();
					func      <= next_req.func;
					position  <= next_req.position;
					new_value <= next_req.new_value;
					req_valid <= 1'b1;
					if (burst_left <= 1) begin
						// end of burst: pick the next burst and the gap before it
						burst_left <= $urandom_range(1, 48);
						gap_pick = $urandom_range(0, 9);
						if (gap_pick < 4)
							gap_left <= 0;
						else if (gap_pick < 9)
							gap_left <= $urandom_range(1, 5);
						else
							gap_left <= $urandom_range(6, 24);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver: stalls on a pattern of its own, plus long hold-offs
	// ---------------------------------------------------------------
	int hold_seen = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready    <= 1'b0;
			hold_left    <= 0;
			rx_mode      <= 0;
			rx_mode_left <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      <= $urandom_range(0, 3);
				rx_mode_left <= $urandom_range(20, 200);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				0: rsp_ready <= 1'b1;                          // no stalls at all
				1: rsp_ready <= 1'($urandom_range(0, 1));      // even odds
				2: rsp_ready <= ($urandom_range(0, 7) != 0);   // rare stalls
				default: rsp_ready <= ($urandom_range(0, 7) == 0); // mostly stalled
			endcase
		end
	end

	// ---------------------------------------------------------------
	// monitor: every taken response word against the oldest owed one
	// ---------------------------------------------------------------
	vec_rsp_t got;
	vec_rsp_t want;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			got = {read_value, found, status, entry_count};
			words_seen++;
			if (owed_rsps.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected response word read_value=%h found=%b status=%b count=%0d",
					$time, got.read_value, got.found, got.status, got.entry_count);
			end else begin
				want = owed_rsps.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: mismatch expected read_value=%h found=%b status=%b count=%0d",
						$time, want.read_value, want.found, want.status, want.entry_count);
					$display("%0t:          actual   read_value=%h found=%b status=%b count=%0d",
						$time, got.read_value, got.found, got.status, got.entry_count);
				end
			end
		end
	end

	// watchdog: a hang anywhere ends the run as a failure
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timed out with %0d responses still owed", $time, owed_rsps.size());
		$display("CHECK FAILED");
		$finish;
	end

	task automatic queue_req(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
			input logic [VAL_W-1:0] v);
		pending_reqs.push_back({f, p, v});
	endtask

	// sender pause: nothing queued, nothing offered, nothing owed
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || owed_rsps.size() != 0);
	endtask

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	initial begin
		logic [POS_W-1:0] pool[POOL_MAX];
		phase_kind_t      kind;
		int               span;
		int               roll;
		logic [FUNC_W-1:0] op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, edge positions, overwrite, zero values, shifts
		queue_req(OP_GET,    16'h0000, 8'h00); // get on an empty table
		queue_req(OP_REMOVE, 16'h0000, 8'h00); // remove with nothing stored
		queue_req(OP_SET,    16'h0064, 8'h00); // zero at an absent position inserts nothing
		queue_req(OP_SET,    16'hFFFF, 8'hFF); // top position, top byte
		queue_req(OP_SET,    16'h0000, 8'h01); // bottom position goes in front
		queue_req(OP_SET,    16'h8000, 8'h80); // middle insert
		queue_req(OP_SET,    16'h1234, 8'h55);
		queue_req(OP_GET,    16'hFFFF, 8'h00);
		queue_req(OP_SPARE,  16'h1234, 8'hEE); // spare code behaves as a get
		queue_req(OP_SET,    16'h1234, 8'h00); // zero at a present position keeps the entry
		queue_req(OP_GET,    16'h1234, 8'h00);
		queue_req(OP_SET,    16'h8000, 8'hAA); // overwrite
		queue_req(OP_SET,    16'h5555, 8'h5A);
		queue_req(OP_SET,    16'hAAAA, 8'hA5);
		queue_req(OP_REMOVE, 16'h1234, 8'h00); // remove from the middle
		queue_req(OP_REMOVE, 16'h0000, 8'h00); // remove the first entry
		queue_req(OP_REMOVE, 16'hFFFF, 8'h00); // remove the last entry
		queue_req(OP_REMOVE, 16'h7777, 8'h00); // remove of an absent position
		queue_req(OP_GET,    16'h8000, 8'h00);
		queue_req(OP_REMOVE, 16'h5555, 8'h00);
		queue_req(OP_REMOVE, 16'h8000, 8'h00);
		queue_req(OP_REMOVE, 16'hAAAA, 8'h00); // table empty again
		queue_req(OP_GET,    16'hAAAA, 8'h00);
		wait_drained();

		// random phases over a pool a little larger than the table
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			kind = phase_kind_t'(ph % 4);
			if (kind == PH_FILL) begin
				pool[0] = 16'h0000;
				pool[1] = 16'hFFFF;
				for (int i = 2; i < POOL_MAX; i++)
					pool[i] = POS_W'($urandom_range(0, 65535));
			end
			span = (kind == PH_CHURN) ? 40 : POOL_MAX;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 9);
				case (kind)
					PH_FILL:  op = (roll < 8) ? OP_SET : (roll == 8) ? OP_GET : OP_REMOVE;
					PH_CHURN: op = (roll < 4) ? OP_SET : (roll < 7) ? OP_REMOVE :
						(roll < 9) ? OP_GET : OP_SPARE;
					PH_DRAIN: op = (roll < 7) ? OP_REMOVE : (roll == 7) ? OP_SET :
						(roll == 8) ? OP_GET : OP_SPARE;
					default:  op = (roll < 3) ? OP_GET : (roll == 3) ? OP_SPARE :
						(roll < 5) ? OP_SET : OP_REMOVE;
				endcase
				// wide phase mixes in positions anywhere in the 16-bit range
				if (kind == PH_WIDE && $urandom_range(0, 1) == 0)
					pos = POS_W'($urandom_range(0, 65535));
				else
					pos = pool[$urandom_range(0, span - 1)];
				if (kind == PH_WIDE)
					val = VAL_W'($urandom_range(0, 255));
				else if ($urandom_range(0, 7) == 0)
					val = '0;
				else
					val = VAL_W'($urandom_range(1, 255));
				queue_req(op, pos, val);
			end
			// long receiver hold-off while the sender keeps offering words
			if (ph == 0 || ph == 4) begin
				@(negedge clk);
				hold_req++;
			end
			wait_drained();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (owed_rsps.size() != 0) begin
			mismatches++;
			$display("%0t: %0d responses never arrived", $time, owed_rsps.size());
		end

		$display("ran %0d request words, %0d response words: %0d hits, %0d refused inserts",
			words_sent, words_seen, hits_seen, refusals_seen);
		$display("peak fill %0d of %0d entries, %0d mismatches", peak_used, CAPACITY, mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
